// File: src/imucf_pkg.sv
// Shared constants, types and the arctangent table of the attitude filter.
`default_nettype none
package imucf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // Configuration register indexes.
    localparam logic REG_RESTRICT = 1'b0;
    localparam logic REG_GFS      = 1'b1;

    localparam logic signed [33:0] DEG180  = 34'sd11796480;
    localparam logic signed [33:0] DEG360  = 34'sd23592960;
    localparam logic signed [21:0] W_GYRO  = 22'sd62259;
    localparam logic signed [21:0] W_ACCEL = 22'sd3277;
    localparam logic signed [21:0] ROT_K   = 22'sd46341;
    localparam logic signed [31:0] FS_BASE = 32'sd250;

    typedef logic signed [31:0] t_angle;
    typedef logic signed [17:0] t_vec;

    // atan(2^-i) in Q16.16 degrees.
    function automatic t_angle atan_entry(input logic [4:0] idx);
        t_angle v;
        unique case (idx)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            5'd17:   v = 32'sd29;
            5'd18:   v = 32'sd14;
            5'd19:   v = 32'sd7;
            5'd20:   v = 32'sd4;
            5'd21:   v = 32'sd2;
            5'd22:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/imucf_in_if.sv
// Input channel: one set of raw sensor samples and a time step.
`default_nettype none
interface imucf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic        [19:0] step_seconds;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    step_seconds, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    step_seconds, output ready);
endinterface
`default_nettype wire

// File: src/imucf_out_if.sv
// Output channel: airframe roll, pitch and yaw.
`default_nettype none
interface imucf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;

    modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
    modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

// File: src/imucf_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module imucf_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_value,
    output logic             o_busy,
    output logic      [15:0] o_root
);
    logic [30:0] r_bit;
    logic [31:0] r_v;
    logic [32:0] r_res;
    logic [32:0] n_trial;

    assign n_trial = r_res + {2'b00, r_bit};
    assign o_busy  = |r_bit;
    assign o_root  = r_res[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= 31'h4000_0000;
            r_v   <= i_value;
            r_res <= '0;
        end else if (o_busy) begin
            if ({1'b0, r_v} >= n_trial) begin
                r_v   <= 32'({1'b0, r_v} - n_trial);
                r_res <= (r_res >> 1) + {2'b00, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule
`default_nettype wire

// File: src/imucf_cordic.sv
// Iterative CORDIC vectoring unit giving atan2(y, x) in Q16.16 degrees.
`default_nettype none
module imucf_cordic #(
    parameter int CORDIC_STEPS = imucf_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire imucf_pkg::t_vec   i_y,
    input  wire imucf_pkg::t_vec   i_x,
    output logic                   o_busy,
    output imucf_pkg::t_angle      o_angle
);
    localparam int N  = (CORDIC_STEPS < imucf_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                               : imucf_pkg::TABLE_LEN;
    localparam int CW = $clog2(N + 1);

    logic                    r_busy;
    logic                    r_skip;
    logic [CW-1:0]           r_i;
    logic signed [33:0]      r_x;
    logic signed [33:0]      r_y;
    imucf_pkg::t_angle       r_z;
    imucf_pkg::t_angle       r_base;
    logic signed [33:0]      n_x;
    logic signed [33:0]      n_y;
    imucf_pkg::t_angle       n_z;
    logic signed [33:0]      c_xe;
    logic signed [33:0]      c_ye;
    imucf_pkg::t_angle       c_step;

    assign c_xe   = 34'(i_x);
    assign c_ye   = 34'(i_y);
    assign c_step = imucf_pkg::atan_entry(5'(r_i));

    always_comb begin
        if (r_y >= 0) begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
            n_z = r_z + c_step;
        end else begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
            n_z = r_z - c_step;
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_base + r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_z    <= '0;
            r_skip <= (i_y == 0);
            // A left half-plane vector is turned through 180 degrees first.
            if (i_y == 0) begin
                r_base <= (i_x < 0) ? 32'(imucf_pkg::DEG180) : 32'sd0;
            end else if (i_x < 0) begin
                r_base <= (i_y > 0) ? 32'(imucf_pkg::DEG180) : 32'(-imucf_pkg::DEG180);
            end else begin
                r_base <= 32'sd0;
            end
            r_x <= ((i_x < 0) ? -c_xe : c_xe) <<< 12;
            r_y <= ((i_x < 0) ? -c_ye : c_ye) <<< 12;
        end else if (r_busy) begin
            if (r_skip || (r_i == CW'(N))) begin
                r_busy <= 1'b0;
            end else begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// File: src/imu_complementary_filter.sv
// Top level of the complementary-filter attitude estimator and its sequencer.
//
//   channel   direction  transaction
//   i_in      in         accel x/y/z, gyro x/y/z, step_seconds
//   o_out     out        roll_deg, pitch_deg, yaw_deg
//   i_cfg_*   in         write of the arctangent mode or gyro_full_scale
//
// One transaction occupies the block from its accepting cycle until it is back in idle:
// the shared multiplier is used in turn for the gyro increments, squares, fusion and
// rotation, and the CORDIC unit runs twice, the first time alongside the square root.
// Yaw wrapping takes one turn off or on per step until the yaw is in range, and
// an arctangent of a vector with zero y finishes early.
// Synchronous reset clears the kept angles and sets arctangent mode 0, gyro_full_scale 1.
// A finished result sits in the output register while the next transaction
// is accepted; the sequencer waits at its end only if that register is full.
`default_nettype none
module imu_complementary_filter #(
    parameter int CORDIC_STEPS = imucf_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    imucf_in_if.sink        i_in,
    imucf_out_if.source     o_out,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [1:0] i_cfg_data
);
    typedef enum logic [19:0] {
        S_IDLE = 20'h00001, S_G1  = 20'h00002, S_G2  = 20'h00004, S_G3  = 20'h00008,
        S_SQ1  = 20'h00010, S_SQ2 = 20'h00020, S_SQ3 = 20'h00040, S_SQW = 20'h00080,
        S_ATW  = 20'h00100, S_F1  = 20'h00200, S_F2  = 20'h00400, S_F3  = 20'h00800,
        S_F4   = 20'h01000, S_F5  = 20'h02000, S_R1  = 20'h04000, S_R2  = 20'h08000,
        S_R3   = 20'h10000, S_YW  = 20'h20000, S_OUT = 20'h40000, S_SPR = 20'h80000
    } t_state;

    t_state                r_state;
    logic                  r_restrict;
    logic [1:0]            r_gfs;
    logic signed [15:0]    r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic [19:0]           r_dt;
    logic [1:0]            r_axis;
    logic signed [33:0]    r_groll, r_gpitch, r_gyaw;
    imucf_pkg::t_angle     r_fr, r_fp, r_iy;
    logic signed [55:0]    r_prod, r_acc;
    logic [31:0]           r_sq;
    imucf_pkg::t_angle     r_aroll, r_apitch;
    logic signed [15:0]    r_rroll, r_rpitch;
    logic                  r_ovalid;
    logic signed [15:0]    r_oroll, r_opitch, r_oyaw;

    logic signed [33:0]    m_a;
    logic signed [21:0]    m_b;
    logic signed [15:0]    c_gsel;
    imucf_pkg::t_angle     c_ssel;
    logic signed [33:0]    c_inc;
    logic signed [33:0]    c_gnew;
    logic signed [55:0]    c_fsum;
    logic signed [39:0]    c_fr;
    imucf_pkg::t_angle     c_fsat;
    logic signed [30:0]    c_rot;
    logic signed [15:0]    c_rsat;
    logic signed [25:0]    c_yaw;
    logic signed [15:0]    c_ysat;
    logic signed [17:0]    c_negax;
    logic                  isq_start, isq_busy;
    logic [15:0]           isq_root;
    logic                  cor_start, cor_busy;
    imucf_pkg::t_vec       cor_y, cor_x;
    imucf_pkg::t_angle     cor_angle;
    logic                  out_free;

    assign c_negax = -18'(r_ax);
    assign out_free = !r_ovalid || o_out.ready;

    always_comb begin
        unique case (r_axis)
            2'd0:    begin c_gsel = r_gx; c_ssel = r_fr; end
            2'd1:    begin c_gsel = r_gy; c_ssel = r_fp; end
            default: begin c_gsel = r_gz; c_ssel = r_iy; end
        endcase
    end

    // Rounded right shifts: add half, then shift arithmetically.
    assign c_inc  = 34'((r_prod + 56'sd262144) >>> 19);
    assign c_gnew = 34'(c_ssel) + c_inc;
    assign c_fsum = r_acc + r_prod;
    assign c_fr   = 40'((c_fsum + 56'sd32768) >>> 16);
    assign c_fsat = (c_fr > 40'sd2147483647)  ? 32'sh7fffffff :
                    (c_fr < -40'sd2147483648) ? 32'sh80000000 : 32'(c_fr);
    assign c_rot  = 31'((r_prod + 56'sd16777216) >>> 25);
    assign c_rsat = (c_rot > 31'sd32767)  ? 16'sd32767 :
                    (c_rot < -31'sd32768) ? -16'sd32768 : 16'(c_rot);
    assign c_yaw  = 26'((-r_gyaw + 34'sd256) >>> 9);
    assign c_ysat = (c_yaw > 26'sd23040)  ? 16'sd23040 :
                    (c_yaw < -26'sd23040) ? -16'sd23040 : 16'(c_yaw);

    always_comb begin
        m_a = 34'(r_ax);
        m_b = 22'(r_ax);
        unique case (r_state)
            S_G1:  begin m_a = 34'(c_gsel); m_b = 22'(imucf_pkg::FS_BASE <<< r_gfs); end
            S_G2:  begin m_a = r_prod[33:0]; m_b = {2'b00, r_dt}; end
            S_SQ1: begin
                m_a = r_restrict ? 34'(r_ay) : 34'(r_ax);
                m_b = r_restrict ? 22'(r_ay) : 22'(r_ax);
            end
            S_SQ2: begin m_a = 34'(r_az); m_b = 22'(r_az); end
            S_F1:  begin m_a = r_groll; m_b = imucf_pkg::W_GYRO; end
            S_F2:  begin m_a = 34'(r_aroll); m_b = imucf_pkg::W_ACCEL; end
            S_F3:  begin m_a = r_gpitch; m_b = imucf_pkg::W_GYRO; end
            S_F4:  begin m_a = 34'(r_apitch); m_b = imucf_pkg::W_ACCEL; end
            S_R1:  begin m_a = 34'(r_fp) - 34'(r_fr); m_b = imucf_pkg::ROT_K; end
            S_R2:  begin m_a = 34'(r_fr) + 34'(r_fp); m_b = imucf_pkg::ROT_K; end
            default: ;
        endcase
    end

    always_comb begin
        cor_start = 1'b0;
        cor_y     = 18'(r_ay);
        cor_x     = 18'(r_az);
        if (r_state == S_SQ3) begin
            cor_start = 1'b1;
            cor_y     = r_restrict ? 18'(r_ay) : c_negax;
        end else if (r_state == S_SQW && !isq_busy && !cor_busy) begin
            cor_start = 1'b1;
            cor_y     = r_restrict ? c_negax : 18'(r_ay);
            cor_x     = {2'b00, isq_root};
        end
    end
    assign isq_start = (r_state == S_SQ3);

    imucf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (isq_start),
        .i_value (r_sq + r_prod[31:0]),
        .o_busy  (isq_busy),
        .o_root  (isq_root)
    );

    imucf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_y     (cor_y),
        .i_x     (cor_x),
        .o_busy  (cor_busy),
        .o_angle (cor_angle)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.roll_deg  = r_oroll;
    assign o_out.pitch_deg = r_opitch;
    assign o_out.yaw_deg   = r_oyaw;

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * 56'(m_b);
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_restrict <= 1'b0;
            r_gfs      <= 2'd1;
            r_fr       <= '0;
            r_fp       <= '0;
            r_iy       <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    imucf_pkg::REG_RESTRICT: r_restrict <= i_cfg_data[0];
                    imucf_pkg::REG_GFS:      r_gfs      <= i_cfg_data;
                    default: ;
                endcase
            end
            // In S_OUT the output register is handled by the sequencer below.
            if (r_ovalid && o_out.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_ax   <= i_in.accel_x;
                        r_ay   <= i_in.accel_y;
                        r_az   <= i_in.accel_z;
                        r_gx   <= i_in.gyro_x;
                        r_gy   <= i_in.gyro_y;
                        r_gz   <= i_in.gyro_z;
                        r_dt   <= i_in.step_seconds;
                        r_axis <= 2'd0;
                        r_state <= S_G1;
                    end
                end
                S_G1: r_state <= S_G2;
                S_G2: r_state <= S_G3;
                S_G3: begin
                    unique case (r_axis)
                        2'd0:    r_groll  <= c_gnew;
                        2'd1:    r_gpitch <= c_gnew;
                        default: r_gyaw   <= c_gnew;
                    endcase
                    r_axis  <= r_axis + 2'd1;
                    r_state <= (r_axis == 2'd2) ? S_SQ1 : S_G1;
                end
                S_SQ1: r_state <= S_SQ2;
                S_SQ2: begin
                    r_sq    <= r_prod[31:0];
                    r_state <= S_SQ3;
                end
                S_SQ3: r_state <= S_SQW;
                S_SQW: begin
                    if (!isq_busy && !cor_busy) begin
                        if (r_restrict) r_aroll  <= cor_angle;
                        else            r_apitch <= cor_angle;
                        r_state <= S_ATW;
                    end
                end
                S_ATW: begin
                    if (!cor_busy) begin
                        if (r_restrict) r_apitch <= cor_angle;
                        else            r_aroll  <= cor_angle;
                        r_state <= S_F1;
                    end
                end
                S_F1: r_state <= S_F2;
                S_F2: begin
                    r_acc   <= r_prod;
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_fr    <= c_fsat;
                    r_state <= S_F4;
                end
                S_F4: begin
                    r_acc   <= r_prod;
                    r_state <= S_F5;
                end
                S_F5: begin
                    r_fp    <= c_fsat;
                    r_state <= S_R1;
                end
                S_R1: r_state <= S_R2;
                S_R2: begin
                    r_rroll <= c_rsat;
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_rpitch <= c_rsat;
                    r_state  <= S_YW;
                end
                S_YW: begin
                    // Bring the kept yaw back into [-180, 180) one turn at a time.
                    if (r_gyaw >= imucf_pkg::DEG180) begin
                        r_gyaw <= r_gyaw - imucf_pkg::DEG360;
                    end else if (r_gyaw < -imucf_pkg::DEG180) begin
                        r_gyaw <= r_gyaw + imucf_pkg::DEG360;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_iy     <= 32'(r_gyaw);
                        r_oroll  <= r_rroll;
                        r_opitch <= r_rpitch;
                        r_oyaw   <= c_ysat;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a transaction is in progress");
    a_yaw_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_gyaw >= -imucf_pkg::DEG180 &&
                                r_gyaw < imucf_pkg::DEG180))
        else $error("kept yaw left its wrapped range");
    a_units_idle_in_fusion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F1) |-> (!cor_busy && !isq_busy))
        else $error("fusion started before the angle units finished");
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_oyaw <= 16'sd23040 && r_oyaw >= -16'sd23040))
        else $error("output yaw outside plus or minus 180 degrees");
`endif

endmodule
`default_nettype wire
